FILE: hdl/dsw_pkg.sv
// ----------------------------------------------------------------------------
// dsw_pkg
// Shared types, constants and calendar helpers for the date span and weekday
// unit. Years are offsets from 2000; 2000 is a leap year, 2100 is not.
// ----------------------------------------------------------------------------
package dsw_pkg;

  localparam int YEAR_W  = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ORD_W   = 16;
  localparam int WDAY_W  = 3;
  localparam int MBASE_W = 9;

  localparam int YEAR_SPAN_DEFAULT = 102;

  // Year offset of 2100, the only non-leap year divisible by four in range
  localparam logic [YEAR_W-1:0] CENTURY_NONLEAP = 7'd100;

  // Day number of Monday 2001-01-01, counted from 2000-01-01
  localparam logic [ORD_W-1:0] MONDAY_ORDINAL = 16'd366;

  localparam logic [ORD_W-1:0] DAYS_PER_YEAR = 16'd365;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [WDAY_W-1:0] WDAY_NONE = 3'd0;

  typedef struct packed {
    logic              invalid;
    logic [ORD_W-1:0]  ordinal;
    logic [WDAY_W-1:0] weekday;
  } date_info_t;

  // Length of a month; 0 for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of the month
  function automatic logic [MBASE_W-1:0] days_before_month(input logic [MONTH_W-1:0] month,
                                                          input logic leap);
    logic [MBASE_W-1:0] base;
    case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (month > MONTH_FEB)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Remainder by 7: 8 = 1 mod 7, so fold the octal digits until small
  function automatic logic [2:0] mod7(input logic [ORD_W-1:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    logic [2:0] r;
    s1 = 6'(x[15]) + 6'(x[14:12]) + 6'(x[11:9]) + 6'(x[8:6]) + 6'(x[5:3]) + 6'(x[2:0]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    r  = (s3[2:0] == 3'd7) ? 3'd0 : s3[2:0];
    return r;
  endfunction

  // Weekday 1 (Monday) .. 7 from the day number remainder; 366 = 2 mod 7
  function automatic logic [WDAY_W-1:0] weekday_from_rem(input logic [2:0] rem);
    logic [WDAY_W-1:0] wd;
    case (rem)
      3'd2:    wd = 3'd1;
      3'd3:    wd = 3'd2;
      3'd4:    wd = 3'd3;
      3'd5:    wd = 3'd4;
      3'd6:    wd = 3'd5;
      3'd0:    wd = 3'd6;
      3'd1:    wd = 3'd7;
      default: wd = WDAY_NONE;
    endcase
    return wd;
  endfunction

endpackage

FILE: hdl/dsw_date_eval.sv
// ----------------------------------------------------------------------------
// dsw_date_eval
// Checks one date and gives its day number from 2000-01-01 and its weekday.
// Purely combinational; sits between the input and result registers.
// ----------------------------------------------------------------------------
module dsw_date_eval #(
  parameter int YEAR_SPAN = dsw_pkg::YEAR_SPAN_DEFAULT
) (
  input  logic [dsw_pkg::YEAR_W-1:0]  year,
  input  logic [dsw_pkg::MONTH_W-1:0] month,
  input  logic [dsw_pkg::DAY_W-1:0]   day,
  output dsw_pkg::date_info_t         info
);

  logic                          leap;
  logic [dsw_pkg::DAY_W-1:0]     mlen;
  logic                          ok;
  logic                          past_2100;
  logic [5:0]                    leaps_before;
  logic [dsw_pkg::MBASE_W-1:0]   month_base;
  logic [dsw_pkg::ORD_W-1:0]     year_base;
  logic [dsw_pkg::ORD_W-1:0]     ordinal;

  assign leap = (year[1:0] == 2'b00) && (year != dsw_pkg::CENTURY_NONLEAP);
  assign mlen = dsw_pkg::month_length(month, leap);

  assign ok = ({1'b0, year} < 8'(YEAR_SPAN))
           && (month >= dsw_pkg::MONTH_JAN) && (month <= dsw_pkg::MONTH_DEC)
           && (day != '0) && (day <= mlen);

  // Leap years in [2000, 2000 + year): every fourth one, less 2100
  assign past_2100    = (year > dsw_pkg::CENTURY_NONLEAP);
  assign leaps_before = 6'((8'(year) + 8'd3) >> 2) - 6'(past_2100);
  assign month_base   = dsw_pkg::days_before_month(month, leap);
  assign year_base    = 16'(year) * dsw_pkg::DAYS_PER_YEAR;

  always_comb begin
    ordinal = '0;
    if (ok) begin
      ordinal = year_base + 16'(leaps_before) + 16'(month_base) + 16'(day) - 16'd1;
    end
  end

  assign info.invalid = !ok;
  assign info.ordinal = ordinal;
  assign info.weekday = (ok && (ordinal >= dsw_pkg::MONDAY_ORDINAL))
                      ? dsw_pkg::weekday_from_rem(dsw_pkg::mod7(ordinal))
                      : dsw_pkg::WDAY_NONE;

endmodule

FILE: hdl/date_span_and_weekday.sv
// Path: an input transfer loads the input register, then the result register
//   with the date arithmetic between them.
// Throughput: one item per cycle; the input register refills whenever the
//   result register is empty or its result is taken in the same cycle.
// Reset: synchronous, active high; empties both stages, no kept state.
// ----------------------------------------------------------------------------
// date_span_and_weekday
// Validates two dates in 2000 .. 2000+YEAR_SPAN-1, gives the start-to-end day
// count, an end-before-start flag and the weekday of each date from 2001 on.
// ----------------------------------------------------------------------------
module date_span_and_weekday #(
  parameter int YEAR_SPAN = dsw_pkg::YEAR_SPAN_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dsw_pkg::YEAR_W-1:0]  start_year,
  input  logic [dsw_pkg::MONTH_W-1:0] start_month,
  input  logic [dsw_pkg::DAY_W-1:0]   start_day,
  input  logic [dsw_pkg::YEAR_W-1:0]  end_year,
  input  logic [dsw_pkg::MONTH_W-1:0] end_month,
  input  logic [dsw_pkg::DAY_W-1:0]   end_day,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        start_invalid,
  output logic                        end_invalid,
  output logic                        reversed,
  output logic [dsw_pkg::ORD_W-1:0]   day_difference,
  output logic [dsw_pkg::WDAY_W-1:0]  start_weekday,
  output logic [dsw_pkg::WDAY_W-1:0]  end_weekday
);

  // Input register
  logic                        s0_valid;
  logic [dsw_pkg::YEAR_W-1:0]  s0_start_year;
  logic [dsw_pkg::MONTH_W-1:0] s0_start_month;
  logic [dsw_pkg::DAY_W-1:0]   s0_start_day;
  logic [dsw_pkg::YEAR_W-1:0]  s0_end_year;
  logic [dsw_pkg::MONTH_W-1:0] s0_end_month;
  logic [dsw_pkg::DAY_W-1:0]   s0_end_day;

  logic                        s0_advance;
  dsw_pkg::date_info_t         start_info;
  dsw_pkg::date_info_t         end_info;
  logic                        both_ok;
  logic                        rev_next;
  logic [dsw_pkg::ORD_W-1:0]   span_next;

  assign s0_advance = s0_valid && (!out_valid || out_ready);
  assign in_ready   = !s0_valid || s0_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_start_year  <= start_year;
      s0_start_month <= start_month;
      s0_start_day   <= start_day;
      s0_end_year    <= end_year;
      s0_end_month   <= end_month;
      s0_end_day     <= end_day;
    end
  end

  dsw_date_eval #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_start_eval (
    .year  (s0_start_year),
    .month (s0_start_month),
    .day   (s0_start_day),
    .info  (start_info)
  );

  dsw_date_eval #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_end_eval (
    .year  (s0_end_year),
    .month (s0_end_month),
    .day   (s0_end_day),
    .info  (end_info)
  );

  assign both_ok   = !start_info.invalid && !end_info.invalid;
  assign rev_next  = both_ok && (end_info.ordinal < start_info.ordinal);
  assign span_next = (both_ok && !rev_next) ? (end_info.ordinal - start_info.ordinal) : '0;

  // Result register: load on advance, drop valid once the result transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s0_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_advance) begin
      start_invalid  <= start_info.invalid;
      end_invalid    <= end_info.invalid;
      reversed       <= rev_next;
      day_difference <= span_next;
      start_weekday  <= start_info.weekday;
      end_weekday    <= end_info.weekday;
    end
  end

endmodule

FILE: hdl/dsw_checker.sv
// ----------------------------------------------------------------------------
// dsw_checker
// Port-level checks for the date span and weekday unit, bound to the top.
// ----------------------------------------------------------------------------
module dsw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        start_invalid,
  input logic                        end_invalid,
  input logic                        reversed,
  input logic [dsw_pkg::ORD_W-1:0]   day_difference,
  input logic [dsw_pkg::WDAY_W-1:0]  start_weekday,
  input logic [dsw_pkg::WDAY_W-1:0]  end_weekday
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(day_difference)
      && $stable(reversed) && $stable(start_weekday) && $stable(end_weekday))
    else $error("result changed while stalled");

  a_rev_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && reversed |-> !start_invalid && !end_invalid && (day_difference == '0))
    else $error("reversed flag with invalid date or nonzero span");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (start_invalid || end_invalid) |-> (day_difference == '0) && !reversed)
    else $error("span reported for invalid date");

  a_invalid_wday: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!start_invalid || (start_weekday == dsw_pkg::WDAY_NONE))
      && (!end_invalid || (end_weekday == dsw_pkg::WDAY_NONE)))
    else $error("weekday reported for invalid date");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind date_span_and_weekday dsw_checker u_dsw_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .start_invalid  (start_invalid),
  .end_invalid    (end_invalid),
  .reversed       (reversed),
  .day_difference (day_difference),
  .start_weekday  (start_weekday),
  .end_weekday    (end_weekday)
);
